// ===== hdl/sce_pkg.sv =====
// Shared types, constants and helpers for the spectral coherency estimator.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package sce_pkg;

  // Field and datapath widths
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 48;
  localparam int POW_BITS    = 2 * SAMPLE_BITS;   // |x|^2, |y|^2, |xy|
  localparam int RAD_BITS    = 2 * POW_BITS;      // radicand of the root unit
  localparam int FRAC_BITS   = 16;
  localparam int COH_BITS    = FRAC_BITS + 1;     // Q0.16 plus the 1.0 code
  localparam int QUO_BITS    = 2 * FRAC_BITS;     // quotient fed to the root
  localparam int DEN_BITS    = 2 * SUM_BITS;      // Px*Py and S*S
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COH_BITS-1:0] COH_ONE = COH_BITS'(1) << FRAC_BITS;

  // Status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_ZERO = 2'd1;
  localparam status_t STAT_SAT  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x_real;
    logic signed [SAMPLE_BITS-1:0] x_imag;
    logic signed [SAMPLE_BITS-1:0] y_real;
    logic signed [SAMPLE_BITS-1:0] y_imag;
    logic                          last_sample;
  } sample_t;

  typedef struct packed {
    logic [COH_BITS-1:0] coherency;
    status_t             status;
  } result_t;

  // Word passed from the front end to the back end
  typedef struct packed {
    logic [POW_BITS-1:0] px;
    logic [POW_BITS-1:0] py;
    logic                last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_ROOT,
    B_ACC,
    B_ZCHK,
    B_DMUL,
    B_SMUL,
    B_CMP,
    B_DIV,
    B_QROOT,
    B_DONE
  } back_state_t;

  // Saturating accumulate; MSB of the result is the saturation flag
  function automatic logic [SUM_BITS:0] sat_add(input logic [SUM_BITS-1:0] acc,
                                                 input logic [POW_BITS-1:0] add);
    logic [SUM_BITS:0] s;
    s = {1'b0, acc} + (SUM_BITS+1)'(add);
    if (s[SUM_BITS]) begin
      s = {1'b1, {SUM_BITS{1'b1}}};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sce_front.sv =====
// Front end: accepts sample words, forms both channel powers, hands them on.
// Depends on sce_pkg.
`default_nettype none

module sce_front (
  input  logic            clk,
  input  logic            rst,
  input  sce_pkg::sample_t sample,
  input  logic            sample_valid,
  output logic            sample_ready,
  output sce_pkg::entry_t entry,
  output logic            push,
  input  sce_pkg::qstat_t qstat
);
  import sce_pkg::*;

  logic                       s_valid;
  entry_t                     s_entry;
  logic signed [POW_BITS-1:0] xr2, xi2, yr2, yi2;
  logic        [POW_BITS-1:0] px_in, py_in;

  // Channel powers; the sum fits POW_BITS unsigned
  assign xr2   = sample.x_real * sample.x_real;
  assign xi2   = sample.x_imag * sample.x_imag;
  assign yr2   = sample.y_real * sample.y_real;
  assign yi2   = sample.y_imag * sample.y_imag;
  assign px_in = xr2 + xi2;
  assign py_in = yr2 + yi2;

  // Handshake
  assign push         = s_valid && !qstat.full;
  assign sample_ready = !s_valid || push;
  assign entry        = s_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample_ready) begin
      s_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      s_entry <= '{px: px_in, py: py_in, last: sample.last_sample};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sce_queue.sv =====
// Short register queue between front and back ends.
// Depends on sce_pkg.
`default_nettype none

module sce_queue #(
  parameter int DEPTH = sce_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sce_pkg::entry_t entry,
  input  logic            pop,
  output sce_pkg::entry_t head,
  output sce_pkg::qstat_t qstat
);
  import sce_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign head        = mem[rptr];
  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sce_back.sv =====
// Back end: per-sample root and saturating sums, end-of-run coherency
// (shift-add multiply, long division, digit root) and the result register.
// Depends on sce_pkg.
`default_nettype none

module sce_back (
  input  logic             clk,
  input  logic             rst,
  input  sce_pkg::entry_t  head,
  input  sce_pkg::qstat_t  qstat,
  output logic             pop,
  output sce_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_ready
);
  import sce_pkg::*;

  localparam int DCW = $clog2(QUO_BITS);
  localparam logic [RAD_BITS-1:0] SQ_ONE = RAD_BITS'(1) << (RAD_BITS - 2);

  back_state_t state, state_next;

  logic [POW_BITS-1:0] px, py;
  logic                last;
  logic [RAD_BITS-1:0] sq_op, sq_res, sq_one, sq_try, sq_res_next;
  logic                sq_ge;
  logic [SUM_BITS-1:0] cross_sum, px_sum, py_sum;
  logic                sat_flag;
  logic [SUM_BITS:0]   add_c, add_x, add_y;
  logic [DEN_BITS-1:0] mc, prod, den, mul_add;
  logic [SUM_BITS-1:0] mp;
  logic                mul_done;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS:0]   rem2, rem_sub;
  logic                div_ge;
  logic [QUO_BITS-1:0] quo, quo_next;
  logic [DCW-1:0]      dcnt;
  logic [COH_BITS-1:0] coh;
  status_t             stat;
  logic                zero_pow, out_free, load_out;
  result_t             res_reg;

  // Root step: one result bit per cycle
  assign sq_try      = sq_res + sq_one;
  assign sq_ge       = (sq_op >= sq_try);
  assign sq_res_next = sq_ge ? (sq_res >> 1) + sq_one : sq_res >> 1;

  // Multiply and divide steps
  assign mul_add  = prod + mc;
  assign mul_done = (mp == '0);
  assign rem2     = {rem, 1'b0};
  assign rem_sub  = rem2 - {1'b0, den};
  assign div_ge   = (rem2 >= {1'b0, den});
  assign quo_next = {quo[QUO_BITS-2:0], div_ge};

  // Sum updates
  assign add_c = sat_add(cross_sum, sq_res[POW_BITS-1:0]);
  assign add_x = sat_add(px_sum, px);
  assign add_y = sat_add(py_sum, py);

  assign zero_pow = (px_sum == '0) || (py_sum == '0);
  assign out_free = !result_valid || result_ready;
  assign result   = res_reg;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!qstat.empty) state_next = B_MUL;
      B_MUL:   state_next = B_ROOT;
      B_ROOT:  if (sq_one[0]) state_next = B_ACC;
      B_ACC:   state_next = last ? B_ZCHK : B_IDLE;
      B_ZCHK:  state_next = zero_pow ? B_DONE : B_DMUL;
      B_DMUL:  if (mul_done) state_next = B_SMUL;
      B_SMUL:  if (mul_done) state_next = B_CMP;
      B_CMP:   state_next = (prod >= den) ? B_DONE : B_DIV;
      B_DIV:   if (dcnt == DCW'(QUO_BITS - 1)) state_next = B_QROOT;
      B_QROOT: if (sq_one[0]) state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop      = (state == B_IDLE) && !qstat.empty;
    load_out = (state == B_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Run sums and saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_sum <= '0;
      px_sum    <= '0;
      py_sum    <= '0;
      sat_flag  <= 1'b0;
    end else if (state == B_ACC) begin
      cross_sum <= add_c[SUM_BITS-1:0];
      px_sum    <= add_x[SUM_BITS-1:0];
      py_sum    <= add_y[SUM_BITS-1:0];
      if (add_c[SUM_BITS] || add_x[SUM_BITS] || add_y[SUM_BITS]) begin
        sat_flag <= 1'b1;
      end
    end else if (load_out) begin
      cross_sum <= '0;
      px_sum    <= '0;
      py_sum    <= '0;
      sat_flag  <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_reg <= '{coherency: coh, status: stat};
    end
  end

  // Arithmetic datapath
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (pop) begin
          px   <= head.px;
          py   <= head.py;
          last <= head.last;
        end
      end
      B_MUL: begin
        sq_op  <= px * py;
        sq_res <= '0;
        sq_one <= SQ_ONE;
      end
      B_ROOT, B_QROOT: begin
        if (sq_ge) begin
          sq_op <= sq_op - sq_try;
        end
        sq_res <= sq_res_next;
        sq_one <= sq_one >> 2;
        if (state == B_QROOT && sq_one[0]) begin
          coh <= COH_BITS'(sq_res_next);
        end
      end
      B_ZCHK: begin
        prod <= '0;
        mc   <= DEN_BITS'(px_sum);
        mp   <= py_sum;
        if (zero_pow) begin
          coh  <= '0;
          stat <= STAT_ZERO;
        end else begin
          stat <= sat_flag ? STAT_SAT : STAT_OK;
        end
      end
      B_DMUL, B_SMUL: begin
        if (!mul_done) begin
          if (mp[0]) begin
            prod <= mul_add;
          end
          mc <= mc << 1;
          mp <= mp >> 1;
        end else if (state == B_DMUL) begin
          den  <= prod;
          prod <= '0;
          mc   <= DEN_BITS'(cross_sum);
          mp   <= cross_sum;
        end
      end
      B_CMP: begin
        // S^2 >= Px*Py means the ratio reaches 1.0
        if (prod >= den) begin
          coh <= COH_ONE;
        end else begin
          rem  <= prod;
          quo  <= '0;
          dcnt <= '0;
        end
      end
      B_DIV: begin
        rem  <= div_ge ? rem_sub[DEN_BITS-1:0] : rem2[DEN_BITS-1:0];
        quo  <= quo_next;
        dcnt <= dcnt + 1'b1;
        if (dcnt == DCW'(QUO_BITS - 1)) begin
          sq_op  <= RAD_BITS'(quo_next);
          sq_res <= '0;
          sq_one <= SQ_ONE;
        end
      end
      B_ACC, B_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/spectral_coherency_estimator.sv =====
// Top level of the spectral coherency estimator: front end, queue, back end.
// Depends on sce_pkg, sce_front, sce_queue, sce_back.
//
//   port group    dir  word       handshake
//   sample        in   sample_t   sample_valid / sample_ready
//   result        out  result_t   result_valid / result_ready
//
// The front end takes one word a cycle into its power stage and the queue
// while the queue has room. Per sample the back end does one multiply, a
// 32-step digit root and one accumulate, so the shared root unit sets the
// sustained rate. A last sample adds two shift-add multiplies, a 32-step
// division and a second 32-step root; a ratio of 1.0 skips the last two, and
// a zero power sum skips all of them. Reset clears all sums and control; a
// stalled result holds the back end in its final state while the front end
// keeps filling the queue.
`default_nettype none

module spectral_coherency_estimator #(
  parameter int QUEUE_DEPTH = sce_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  sce_pkg::sample_t sample,
  input  logic             sample_valid,
  output logic             sample_ready,
  output sce_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_ready
);
  import sce_pkg::*;

  entry_t entry, head;
  logic   push, pop;
  qstat_t qstat;

  sce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .entry        (entry),
    .push         (push),
    .qstat        (qstat)
  );

  sce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  sce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  // Checks
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("pop from empty queue");

  a_zero_coh: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STAT_ZERO) |-> result.coherency == '0)
    else $error("zero-power result with nonzero coherency");

  a_coh_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.coherency <= COH_ONE)
    else $error("coherency above 1.0");

endmodule

`default_nettype wire
